// File: rtl/core/gmdcs_pkg.sv
// Package for the grid max diagonal cross sum block: sizes, types, codes.
package gmdcs_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLUMNS = 64;
    localparam int VALUE_BITS  = 20;
    localparam int SUM_W       = 27;
    localparam int COUNT_W     = 7;
    localparam int CFG_INDEX_W = 2;

    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int POS_MAX_W = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int CMP_W   = (POS_MAX_W + 1 > COUNT_W) ? POS_MAX_W + 1 : COUNT_W;

    localparam int DIAG_DEPTH = MAX_ROWS + MAX_COLUMNS - 1;
    localparam int DIAG_AW    = (DIAG_DEPTH > 1) ? $clog2(DIAG_DEPTH) : 1;
    localparam int CELL_DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int CELL_AW    = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = CFG_INDEX_W'(1);

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(64);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UPDATE = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_HOLD   = 5'b10000
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic clear;
    } diag_ctl_t;

    // zero acts as one, above max acts as max
    function automatic logic [CMP_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
                                                      input int maxv);
        logic [CMP_W-1:0] lim;
        lim = CMP_W'(maxv);
        if (v == '0)
            return CMP_W'(1);
        else if (CMP_W'(v) > lim)
            return lim;
        else
            return CMP_W'(v);
    endfunction

endpackage

// File: rtl/core/gmdcs_if.sv
// Handshake channels: grid cells in, best sum out.
interface gmdcs_cell_if;
    logic                              valid;
    logic                              ready;
    logic [gmdcs_pkg::VALUE_BITS-1:0]  cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink   (input valid, input cell_value, output ready);
endinterface

interface gmdcs_sum_if;
    logic                          valid;
    logic                          ready;
    logic [gmdcs_pkg::SUM_W-1:0]   best_sum;

    modport source (output valid, output best_sum, input ready);
    modport sink   (input valid, input best_sum, output ready);
endinterface

// File: rtl/core/gmdcs_diag_bank.sv
// Diagonal sum memory with per-entry valid bits; invalid entries read as zero.
module gmdcs_diag_bank (
    input  logic                           clk,
    input  logic                           rst_n,
    input  gmdcs_pkg::diag_ctl_t           ctl,
    input  logic [gmdcs_pkg::DIAG_AW-1:0]  rd_addr,
    input  logic [gmdcs_pkg::DIAG_AW-1:0]  wr_addr,
    input  logic [gmdcs_pkg::SUM_W-1:0]    wr_data,
    output logic [gmdcs_pkg::SUM_W-1:0]    rd_data
);

    logic [gmdcs_pkg::SUM_W-1:0]      mem [gmdcs_pkg::DIAG_DEPTH];
    logic [gmdcs_pkg::DIAG_DEPTH-1:0] valid_reg;
    logic [gmdcs_pkg::SUM_W-1:0]      rd_data_reg;
    logic                             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (ctl.clear)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: rtl/core/grid_max_diagonal_cross_sum_top.sv
// Top level: grid loader, diagonal accumulation and final max scan.
//
//  channel   dir  handshake            payload
//  grid      in   valid/ready          cell_value[19:0]
//  result    out  valid/ready          best_sum[26:0]
//  cfg       in   cfg_wr_en (no wait)  cfg_index[1:0], cfg_data[6:0]
//
// Each cell takes a diagonal read, then add and write back; grid.ready is low
// during the write back. After the last cell a scan runs over rows*columns
// cells, one per cycle, set by the single read port of each memory, then the
// read and compare pipeline drains and the output register is loaded.
// The result sits in an output register; a new grid loads while it waits.
// A second result stalls the scan end until the first is taken.
// Reset and any config write clear the sums and the load position.
module grid_max_diagonal_cross_sum_top (
    input  logic                               clk,
    input  logic                               rst_n,
    gmdcs_cell_if.sink                         grid,
    gmdcs_sum_if.source                        result,
    input  logic                               cfg_wr_en,
    input  logic [gmdcs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gmdcs_pkg::COUNT_W-1:0]      cfg_data
);

    gmdcs_pkg::state_t                state_reg, state_next;
    logic [gmdcs_pkg::COUNT_W-1:0]    row_count_reg, row_count_next;
    logic [gmdcs_pkg::COUNT_W-1:0]    col_count_reg, col_count_next;
    logic [gmdcs_pkg::ROW_W-1:0]      load_row_reg, load_row_next;
    logic [gmdcs_pkg::COL_W-1:0]      load_col_reg, load_col_next;
    logic [gmdcs_pkg::ROW_W-1:0]      scan_row_reg, scan_row_next;
    logic [gmdcs_pkg::COL_W-1:0]      scan_col_reg, scan_col_next;
    logic                             last_reg, last_next;
    logic                             p1_reg, p1_next;
    logic                             p2_reg, p2_next;
    logic [gmdcs_pkg::SUM_W-1:0]      best_reg, best_next;
    logic                             out_valid_reg, out_valid_next;

    logic [gmdcs_pkg::VALUE_BITS-1:0] upd_value_reg;
    logic [gmdcs_pkg::DIAG_AW-1:0]    upd_main_addr_reg, upd_anti_addr_reg;
    logic [gmdcs_pkg::SUM_W-1:0]      sum_reg;
    logic [gmdcs_pkg::SUM_W-1:0]      out_sum_reg;
    logic [gmdcs_pkg::VALUE_BITS-1:0] cell_rd_reg;
    logic [gmdcs_pkg::VALUE_BITS-1:0] cell_mem [gmdcs_pkg::CELL_DEPTH];

    logic [gmdcs_pkg::CMP_W-1:0]      rows_eff, cols_eff;
    logic                             stale;
    logic [gmdcs_pkg::ROW_W-1:0]      cur_row, src_row;
    logic [gmdcs_pkg::COL_W-1:0]      cur_col, src_col;
    logic                             cur_col_last, cur_row_last;
    logic                             scan_col_last, scan_row_last;
    logic                             accept, drain_done, grid_clear, in_scan;
    logic [gmdcs_pkg::DIAG_AW-1:0]    main_addr, anti_addr;
    logic [gmdcs_pkg::CELL_AW-1:0]    load_cell_addr, src_cell_addr;
    logic [gmdcs_pkg::SUM_W-1:0]      main_rd, anti_rd;
    logic [gmdcs_pkg::SUM_W-1:0]      main_wr, anti_wr;
    gmdcs_pkg::diag_ctl_t             diag_ctl;

    assign rows_eff = gmdcs_pkg::clamp_count(row_count_reg, gmdcs_pkg::MAX_ROWS);
    assign cols_eff = gmdcs_pkg::clamp_count(col_count_reg, gmdcs_pkg::MAX_COLUMNS);

    assign stale   = (gmdcs_pkg::CMP_W'(load_row_reg) >= rows_eff)
                  || (gmdcs_pkg::CMP_W'(load_col_reg) >= cols_eff);
    assign cur_row = stale ? '0 : load_row_reg;
    assign cur_col = stale ? '0 : load_col_reg;

    assign cur_col_last  = gmdcs_pkg::CMP_W'(cur_col) + gmdcs_pkg::CMP_W'(1) >= cols_eff;
    assign cur_row_last  = gmdcs_pkg::CMP_W'(cur_row) + gmdcs_pkg::CMP_W'(1) >= rows_eff;
    assign scan_col_last = gmdcs_pkg::CMP_W'(scan_col_reg) + gmdcs_pkg::CMP_W'(1) >= cols_eff;
    assign scan_row_last = gmdcs_pkg::CMP_W'(scan_row_reg) + gmdcs_pkg::CMP_W'(1) >= rows_eff;

    assign grid.ready = (state_reg == gmdcs_pkg::ST_IDLE);
    assign accept     = grid.valid && grid.ready;
    assign in_scan    = (state_reg == gmdcs_pkg::ST_SCAN);

    assign src_row = in_scan ? scan_row_reg : cur_row;
    assign src_col = in_scan ? scan_col_reg : cur_col;

    assign main_addr = gmdcs_pkg::DIAG_AW'(src_row)
                     + gmdcs_pkg::DIAG_AW'(gmdcs_pkg::MAX_COLUMNS - 1)
                     - gmdcs_pkg::DIAG_AW'(src_col);
    assign anti_addr = gmdcs_pkg::DIAG_AW'(src_row) + gmdcs_pkg::DIAG_AW'(src_col);

    assign load_cell_addr = gmdcs_pkg::CELL_AW'(cur_row)
                          * gmdcs_pkg::CELL_AW'(gmdcs_pkg::MAX_COLUMNS)
                          + gmdcs_pkg::CELL_AW'(cur_col);
    assign src_cell_addr  = gmdcs_pkg::CELL_AW'(src_row)
                          * gmdcs_pkg::CELL_AW'(gmdcs_pkg::MAX_COLUMNS)
                          + gmdcs_pkg::CELL_AW'(src_col);

    assign drain_done = (state_reg == gmdcs_pkg::ST_DRAIN) && !p1_reg && !p2_reg;
    assign grid_clear = cfg_wr_en || drain_done;

    assign diag_ctl.wr_en = (state_reg == gmdcs_pkg::ST_UPDATE);
    assign diag_ctl.clear = grid_clear;

    assign main_wr = main_rd + gmdcs_pkg::SUM_W'(upd_value_reg);
    assign anti_wr = anti_rd + gmdcs_pkg::SUM_W'(upd_value_reg);

    gmdcs_diag_bank u_main_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (diag_ctl),
        .rd_addr (main_addr),
        .wr_addr (upd_main_addr_reg),
        .wr_data (main_wr),
        .rd_data (main_rd)
    );

    gmdcs_diag_bank u_anti_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (diag_ctl),
        .rd_addr (anti_addr),
        .wr_addr (upd_anti_addr_reg),
        .wr_data (anti_wr),
        .rd_data (anti_rd)
    );

    // cell store: written on load, read during scan
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cell_mem[load_cell_addr] <= grid.cell_value;
        end
        cell_rd_reg <= cell_mem[src_cell_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        load_row_next  = load_row_reg;
        load_col_next  = load_col_reg;
        scan_row_next  = scan_row_reg;
        scan_col_next  = scan_col_reg;
        last_next      = last_reg;
        p1_next        = in_scan;
        p2_next        = p1_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (p2_reg && (sum_reg > best_reg))
        begin
            best_next = sum_reg;
        end

        case (state_reg)
            gmdcs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = gmdcs_pkg::ST_UPDATE;
                    last_next  = cur_col_last && cur_row_last;
                    if (!cur_col_last)
                    begin
                        load_row_next = cur_row;
                        load_col_next = cur_col + gmdcs_pkg::COL_W'(1);
                    end
                    else
                    begin
                        load_col_next = '0;
                        load_row_next = cur_row_last ? '0 : cur_row + gmdcs_pkg::ROW_W'(1);
                    end
                end
            end
            gmdcs_pkg::ST_UPDATE:
            begin
                if (last_reg)
                begin
                    state_next    = gmdcs_pkg::ST_SCAN;
                    scan_row_next = '0;
                    scan_col_next = '0;
                    best_next     = '0;
                end
                else
                begin
                    state_next = gmdcs_pkg::ST_IDLE;
                end
            end
            gmdcs_pkg::ST_SCAN:
            begin
                if (!scan_col_last)
                begin
                    scan_col_next = scan_col_reg + gmdcs_pkg::COL_W'(1);
                end
                else
                begin
                    scan_col_next = '0;
                    if (scan_row_last)
                    begin
                        state_next = gmdcs_pkg::ST_DRAIN;
                    end
                    else
                    begin
                        scan_row_next = scan_row_reg + gmdcs_pkg::ROW_W'(1);
                    end
                end
            end
            gmdcs_pkg::ST_DRAIN:
            begin
                if (!p1_reg && !p2_reg)
                begin
                    state_next = gmdcs_pkg::ST_HOLD;
                end
            end
            gmdcs_pkg::ST_HOLD:
            begin
                if (drain_done)
                begin
                    state_next = gmdcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gmdcs_pkg::ST_IDLE;
            end
        endcase

        // drain_done only fires in DRAIN; HOLD waits on the output register
        if ((state_reg == gmdcs_pkg::ST_HOLD) && (!out_valid_reg || result.ready))
        begin
            out_valid_next = 1'b1;
            state_next     = gmdcs_pkg::ST_IDLE;
        end

        if (drain_done || ((state_reg == gmdcs_pkg::ST_HOLD)
                           && (!out_valid_reg || result.ready)))
        begin
            load_row_next = '0;
            load_col_next = '0;
        end

        if (cfg_wr_en)
        begin
            if (cfg_index == gmdcs_pkg::REG_ROW_COUNT)
            begin
                row_count_next = cfg_data;
            end
            else if (cfg_index == gmdcs_pkg::REG_COLUMN_COUNT)
            begin
                col_count_next = cfg_data;
            end
            load_row_next = '0;
            load_col_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gmdcs_pkg::ST_IDLE;
            row_count_reg <= gmdcs_pkg::COUNT_RESET;
            col_count_reg <= gmdcs_pkg::COUNT_RESET;
            load_row_reg  <= '0;
            load_col_reg  <= '0;
            scan_row_reg  <= '0;
            scan_col_reg  <= '0;
            last_reg      <= 1'b0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            load_row_reg  <= load_row_next;
            load_col_reg  <= load_col_next;
            scan_row_reg  <= scan_row_next;
            scan_col_reg  <= scan_col_next;
            last_reg      <= last_next;
            p1_reg        <= p1_next;
            p2_reg        <= p2_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            upd_value_reg     <= grid.cell_value;
            upd_main_addr_reg <= main_addr;
            upd_anti_addr_reg <= anti_addr;
        end
        if (p1_reg)
        begin
            sum_reg <= main_rd + anti_rd - gmdcs_pkg::SUM_W'(cell_rd_reg);
        end
        if ((state_reg == gmdcs_pkg::ST_HOLD) && (!out_valid_reg || result.ready))
        begin
            out_sum_reg <= best_reg;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.best_sum = out_sum_reg;

`ifndef SYNTHESIS
    a_accept_then_update: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == gmdcs_pkg::ST_UPDATE))
        else $error("accepted item not followed by diagonal update");

    a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == gmdcs_pkg::ST_HOLD))
        else $error("result raised outside scan completion");

    a_load_pos_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gmdcs_pkg::ST_IDLE) |->
            (gmdcs_pkg::CMP_W'(load_col_reg) < cols_eff))
        else $error("load column outside configured grid");

    a_pipe_empty_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gmdcs_pkg::ST_IDLE) |-> (!p1_reg && !p2_reg))
        else $error("scan pipeline busy while loading");
`endif

endmodule

// File: bench/grid_max_diagonal_cross_sum_top_tb.sv
// Self-checking bench for the grid max diagonal cross sum block: random grids, sizes, stalls.
module grid_max_diagonal_cross_sum_top_tb;

    localparam logic [gmdcs_pkg::CFG_INDEX_W-1:0] REG_UNUSED_LO =
        gmdcs_pkg::CFG_INDEX_W'(2);
    localparam logic [gmdcs_pkg::CFG_INDEX_W-1:0] REG_UNUSED_HI =
        gmdcs_pkg::CFG_INDEX_W'(3);
    localparam logic [gmdcs_pkg::VALUE_BITS-1:0]  VALUE_MAX     = '1;
    localparam int                                RANDOM_ITEMS  = 500;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_MAX,
        FILL_SMALL,
        FILL_ONE_HOT
    } fill_t;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_wr_en;
    logic [gmdcs_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [gmdcs_pkg::COUNT_W-1:0]     cfg_data;

    gmdcs_cell_if grid_ch ();
    gmdcs_sum_if  result_ch ();

    grid_max_diagonal_cross_sum_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .grid      (grid_ch),
        .result    (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the block state
    logic [gmdcs_pkg::VALUE_BITS-1:0] cell_mem [0:gmdcs_pkg::CELL_DEPTH-1];
    logic [gmdcs_pkg::SUM_W-1:0]      main_sum [0:gmdcs_pkg::DIAG_DEPTH-1];
    logic [gmdcs_pkg::SUM_W-1:0]      anti_sum [0:gmdcs_pkg::DIAG_DEPTH-1];
    logic [gmdcs_pkg::COUNT_W-1:0]    row_reg;
    logic [gmdcs_pkg::COUNT_W-1:0]    col_reg;
    int unsigned                      load_r;
    int unsigned                      load_c;

    logic [gmdcs_pkg::VALUE_BITS-1:0] pending_cells [$];
    logic [gmdcs_pkg::SUM_W-1:0]      expected_best_q [$];

    int mismatch_count;
    int send_idle_pct;
    int recv_stall_pct;
    int items_sent;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned effective_count(
        input logic [gmdcs_pkg::COUNT_W-1:0] v,
        input int unsigned limit);
        if (v == '0)
            return 32'd1;
        if (32'(v) > limit)
            return limit;
        return 32'(v);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic clear_sums();
        for (int i = 0; i < gmdcs_pkg::DIAG_DEPTH; i++)
        begin
            main_sum[i] = '0;
            anti_sum[i] = '0;
        end
        load_r = 0;
        load_c = 0;
    endtask

    task automatic track_cell(input logic [gmdcs_pkg::VALUE_BITS-1:0] v);
        int unsigned      rows;
        int unsigned      cols;
        int unsigned      r;
        int unsigned      c;
        longint unsigned  best;
        longint unsigned  s;
        rows = effective_count(row_reg, gmdcs_pkg::MAX_ROWS);
        cols = effective_count(col_reg, gmdcs_pkg::MAX_COLUMNS);
        if (load_r >= rows || load_c >= cols)
        begin
            load_r = 0;
            load_c = 0;
        end
        r = load_r;
        c = load_c;
        cell_mem[r * gmdcs_pkg::MAX_COLUMNS + c] = v;
        main_sum[r + gmdcs_pkg::MAX_COLUMNS - 1 - c] =
            main_sum[r + gmdcs_pkg::MAX_COLUMNS - 1 - c] + gmdcs_pkg::SUM_W'(v);
        anti_sum[r + c] = anti_sum[r + c] + gmdcs_pkg::SUM_W'(v);
        if (c + 1 < cols)
        begin
            load_c = c + 1;
            return;
        end
        load_c = 0;
        if (r + 1 < rows)
        begin
            load_r = r + 1;
            return;
        end
        best = 0;
        for (int unsigned rr = 0; rr < rows; rr++)
            for (int unsigned cc = 0; cc < cols; cc++)
            begin
                s = longint'(main_sum[rr + gmdcs_pkg::MAX_COLUMNS - 1 - cc]) +
                    longint'(anti_sum[rr + cc]) -
                    longint'(cell_mem[rr * gmdcs_pkg::MAX_COLUMNS + cc]);
                if (s > best)
                    best = s;
            end
        expected_best_q.push_back(best[gmdcs_pkg::SUM_W-1:0]);
        clear_sums();
    endtask

    // grid side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_ch.valid      <= 1'b0;
            grid_ch.cell_value <= '0;
        end
        else
        begin
            if (grid_ch.valid && grid_ch.ready)
                track_cell(grid_ch.cell_value);
            if (!grid_ch.valid || grid_ch.ready)
            begin
                if (pending_cells.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    grid_ch.valid      <= 1'b1;
                    grid_ch.cell_value <= pending_cells.pop_front();
                end
                else
                    grid_ch.valid <= 1'b0;
            end
        end
    end

    // result side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_best_q.size() == 0)
                    report_mismatch($sformatf("unexpected best_sum %0d", result_ch.best_sum));
                else
                begin
                    if (result_ch.best_sum !== expected_best_q[0])
                        report_mismatch($sformatf("best_sum %0d, expected %0d",
                                                  result_ch.best_sum, expected_best_q[0]));
                    void'(expected_best_q.pop_front());
                end
            end
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic set_idle_mode(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
        endcase
    endtask

    task automatic drain();
        while (pending_cells.size() != 0 || grid_ch.valid || expected_best_q.size() != 0)
            @(posedge clk);
    endtask

    // register writes only with the block idle
    task automatic write_register(input logic [gmdcs_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [gmdcs_pkg::COUNT_W-1:0] data);
        drain();
        repeat (16) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (index == gmdcs_pkg::REG_ROW_COUNT)
            row_reg = data;
        else if (index == gmdcs_pkg::REG_COLUMN_COUNT)
            col_reg = data;
        clear_sums();
    endtask

    function automatic logic [gmdcs_pkg::VALUE_BITS-1:0] make_value(input fill_t fill);
        case (fill)
            FILL_ZERO:    return '0;
            FILL_MAX:     return VALUE_MAX;
            FILL_SMALL:   return gmdcs_pkg::VALUE_BITS'($urandom_range(0, 3));
            FILL_ONE_HOT: return gmdcs_pkg::VALUE_BITS'(1)
                                 << $urandom_range(0, gmdcs_pkg::VALUE_BITS - 1);
            default:      return gmdcs_pkg::VALUE_BITS'($urandom);
        endcase
    endfunction

    task automatic queue_cells(input int count, input fill_t fill);
        for (int i = 0; i < count; i++)
            pending_cells.push_back(make_value(fill));
        items_sent += count;
    endtask

    function automatic fill_t pick_fill();
        case ($urandom_range(0, 9))
            0:       return FILL_ZERO;
            1:       return FILL_MAX;
            2:       return FILL_SMALL;
            3:       return FILL_ONE_HOT;
            default: return FILL_RANDOM;
        endcase
    endfunction

    task automatic run_phase(input logic [gmdcs_pkg::COUNT_W-1:0] rows_val,
                             input logic [gmdcs_pkg::COUNT_W-1:0] cols_val,
                             input bit write_rows, input int grids, input bit partial);
        int n;
        if (write_rows)
            write_register(gmdcs_pkg::REG_ROW_COUNT, rows_val);
        write_register(gmdcs_pkg::REG_COLUMN_COUNT, cols_val);
        n = effective_count(row_reg, gmdcs_pkg::MAX_ROWS)
          * effective_count(col_reg, gmdcs_pkg::MAX_COLUMNS);
        for (int g = 0; g < grids; g++)
        begin
            queue_cells(n, pick_fill());
            if ($urandom_range(0, 3) == 0)
                drain();
        end
        if (partial && n > 1)
            queue_cells($urandom_range(1, n - 1), FILL_RANDOM);
    endtask

    initial
    begin
        int phase;
        int waited;
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        mismatch_count     = 0;
        items_sent         = 0;
        row_reg            = gmdcs_pkg::COUNT_RESET;
        col_reg            = gmdcs_pkg::COUNT_RESET;
        clear_sums();
        set_idle_mode(0);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero counts act as one: single cell grids
        write_register(gmdcs_pkg::REG_ROW_COUNT, '0);
        write_register(gmdcs_pkg::REG_COLUMN_COUNT, '0);
        pending_cells.push_back('0);
        pending_cells.push_back(VALUE_MAX);
        pending_cells.push_back(gmdcs_pkg::VALUE_BITS'(20'h5A5A5));
        write_register(gmdcs_pkg::REG_ROW_COUNT, gmdcs_pkg::COUNT_W'(2));
        write_register(gmdcs_pkg::REG_COLUMN_COUNT, gmdcs_pkg::COUNT_W'(3));
        queue_cells(6, FILL_MAX);
        // partial grid abandoned by writes to unmapped indexes
        queue_cells(3, FILL_RANDOM);
        write_register(REG_UNUSED_LO, '1);
        queue_cells(2, FILL_RANDOM);
        write_register(REG_UNUSED_HI, '0);
        queue_cells(6, FILL_RANDOM);
        drain();

        items_sent = 0;
        set_idle_mode(1);
        run_phase(gmdcs_pkg::COUNT_W'(127), gmdcs_pkg::COUNT_W'(1), 1'b1, 1, 1'b1);
        set_idle_mode(2);
        run_phase(gmdcs_pkg::COUNT_W'(1), gmdcs_pkg::COUNT_W'(64), 1'b1, 1, 1'b0);
        set_idle_mode(3);
        run_phase(gmdcs_pkg::COUNT_W'(2), gmdcs_pkg::COUNT_W'(100), 1'b1, 1, 1'b1);

        phase = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            set_idle_mode(phase);
            run_phase(gmdcs_pkg::COUNT_W'($urandom_range(0, 5)),
                      gmdcs_pkg::COUNT_W'($urandom_range(0, 5)),
                      $urandom_range(0, 3) != 0, $urandom_range(1, 4),
                      $urandom_range(0, 3) == 0);
            phase++;
        end

        while (pending_cells.size() != 0 || grid_ch.valid)
            @(posedge clk);
        waited = 0;
        while (expected_best_q.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_best_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_best_q.size()));
        repeat (200) @(posedge clk);
        if (mismatch_count == 0)
            $display("grid_max_diagonal_cross_sum_top_tb: clean");
        else
            $display("grid_max_diagonal_cross_sum_top_tb: errors");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("grid_max_diagonal_cross_sum_top_tb: errors");
        $finish;
    end

endmodule
